// ----- design/hn_pkg.sv -----
// Shared constants, types and helper functions of the histogram normalizer.
package hn_pkg;

  localparam int ROW_BINS    = 30;
  localparam int COL_BINS    = 32;
  localparam int COUNT_WIDTH = 22;
  localparam int NUM_BINS    = ROW_BINS * COL_BINS;
  localparam int ADDR_W      = $clog2(NUM_BINS);
  localparam int FRAC_W      = 16;
  localparam int STEP_W      = $clog2(FRAC_W);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [FRAC_W-1:0]      FRAC_MAX  = '1;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  // Request to the bin store.
  typedef struct packed {
    logic              add;
    logic              rd;
    logic              clr;
    logic [ADDR_W-1:0] addr;
  } store_req_t;

  // Status from the bin store.
  typedef struct packed {
    logic                   clearing;
    logic                   rd_done;
    logic [COUNT_WIDTH-1:0] rd_count;
  } store_rsp_t;

  // Request to the fraction divider.
  typedef struct packed {
    logic                   start;
    logic                   ack;
    logic [COUNT_WIDTH-1:0] dividend;
    logic [COUNT_WIDTH-1:0] divisor;
  } div_req_t;

  // Status from the fraction divider.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [FRAC_W-1:0] quotient;
  } div_rsp_t;

  // Joint bin address of a pixel: row = (a*ROW_BINS)>>8, col = (b*COL_BINS)>>8.
  function automatic logic [ADDR_W-1:0] pixel_addr(logic [7:0] a, logic [7:0] b);
    logic [15:0] pa;
    logic [15:0] pb;
    logic [31:0] idx;
    pa  = 16'(32'(a) * ROW_BINS);
    pb  = 16'(32'(b) * COL_BINS);
    idx = 32'(pa[15:8]) * COL_BINS + 32'(pb[15:8]);
    return idx[ADDR_W-1:0];
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(logic [COUNT_WIDTH-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// ----- design/hn_in_if.sv -----
// Request channel interface of the histogram normalizer.
interface hn_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] chan_a;
  logic [7:0] chan_b;
  logic [4:0] bin_row;
  logic [4:0] bin_col;

  modport source (output valid, cmd, chan_a, chan_b, bin_row, bin_col, input ready);
  modport sink   (input valid, cmd, chan_a, chan_b, bin_row, bin_col, output ready);
endinterface

// ----- design/hn_out_if.sv -----
// Result channel interface of the histogram normalizer.
interface hn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] bin_fraction;
  logic [21:0] bin_count;
  logic        empty_flag;

  modport source (output valid, bin_fraction, bin_count, empty_flag, input ready);
  modport sink   (input valid, bin_fraction, bin_count, empty_flag, output ready);
endinterface

// ----- design/two_channel_histogram_normalizer.sv -----
// Top level of the two-channel joint histogram with normalized bin readout.
//
//  channel  dir  modport  payload                                  moves
//  in_ch    in   sink     cmd, chan_a, chan_b, bin_row, bin_col    valid & ready
//  out_ch   out  source   bin_fraction, bin_count, empty_flag      valid & ready
//
// Add requests go one per cycle while in_ch.ready is high: the bin RAM is read
// in the accept cycle and written back the next, with the last written word forwarded.
// A read request: one RAM read, then the 16-step divider, one quotient bit a
// cycle (skipped when the total is zero or the bin holds it all); no request
// is taken until the result loads into the output register.
// Reset and a clear request start a sweep that zeroes all 960 bins, one per
// cycle, with in_ch.ready low throughout the sweep.
// A result waits in the output register; adds are still taken while it stalls.
module two_channel_histogram_normalizer
  import hn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  hn_in_if.sink     in_ch,
  hn_out_if.source  out_ch
);

  store_req_t st_req;
  store_rsp_t st_rsp;
  div_req_t   dv_req;
  div_rsp_t   dv_rsp;

  logic                   in_acc;
  cmd_t                   cmd;
  logic                   rd_oor;
  logic [31:0]            rd_idx;

  // totals and read bookkeeping
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  logic                   rd_pend_r;
  logic                   rd_oor_r;
  logic                   out_load;

  // output register
  logic                   out_valid_r;
  logic [FRAC_W-1:0]      out_frac_r;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic                   out_empty_r;
  logic [COUNT_WIDTH-1:0] res_count_r;
  logic                   res_empty_r;

  assign cmd      = cmd_t'(in_ch.cmd);
  // a read in flight holds off everything until its result is registered
  assign in_ch.ready = !st_rsp.clearing && !rd_pend_r;
  assign in_acc   = in_ch.valid && in_ch.ready;

  assign rd_idx = 32'(in_ch.bin_row) * COL_BINS + 32'(in_ch.bin_col);
  assign rd_oor = (32'(in_ch.bin_row) >= ROW_BINS) || (32'(in_ch.bin_col) >= COL_BINS);

  always_comb begin
    st_req.add  = in_acc && (cmd == CMD_ADD);
    st_req.rd   = in_acc && (cmd == CMD_READ);
    st_req.clr  = in_acc && (cmd == CMD_CLEAR);
    st_req.addr = (cmd == CMD_ADD) ? pixel_addr(in_ch.chan_a, in_ch.chan_b)
                                   : rd_idx[ADDR_W-1:0];
  end

  hn_store u_store (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (st_req),
    .rsp  (st_rsp)
  );

  // result leaves the divider once the output register is free
  assign out_load = dv_rsp.done && (!out_valid_r || out_ch.ready);

  // out-of-range bins read as zero count; a zero dividend gives a zero fraction
  always_comb begin
    dv_req.start    = st_rsp.rd_done;
    dv_req.ack      = out_load;
    dv_req.dividend = rd_oor_r ? '0 : st_rsp.rd_count;
    dv_req.divisor  = total_r;
  end

  hn_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dv_req),
    .rsp  (dv_rsp)
  );

  always_comb begin
    total_nxt = total_r;
    if (st_req.add) begin
      total_nxt = sat_inc(total_r);
    end else if (st_req.clr) begin
      total_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      total_r <= total_nxt;
      if (st_req.rd) begin
        rd_pend_r <= 1'b1;
      end else if (out_load) begin
        rd_pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_req.rd) begin
      rd_oor_r <= rd_oor;
    end
    if (st_rsp.rd_done) begin
      res_count_r <= dv_req.dividend;
      res_empty_r <= (total_r == '0);
    end
    if (out_load) begin
      out_frac_r  <= dv_rsp.quotient;
      out_count_r <= res_count_r;
      out_empty_r <= res_empty_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.bin_fraction = out_frac_r;
  assign out_ch.bin_count    = out_count_r;
  assign out_ch.empty_flag   = out_empty_r;

  // no request may slip in during the clear sweep
  a_no_acc_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    st_rsp.clearing |-> !in_acc)
    else $error("request accepted during clear sweep");

  // a clear request empties the total and starts the sweep
  a_clear_starts: assert property (@(posedge clk) disable iff (!rst_n)
    st_req.clr |=> (st_rsp.clearing && total_r == '0))
    else $error("clear did not start sweep");

  // RAM read data and divider activity only belong to a pending read
  a_rd_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (st_rsp.rd_done || dv_rsp.busy) |-> rd_pend_r)
    else $error("read data without a pending read");

  // the total holds still while a read is being worked out
  a_total_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_pend_r && $past(rd_pend_r)) |-> $stable(total_r))
    else $error("total changed during a read");

endmodule

// ----- design/hn_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module hn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/hn_store.sv -----
// Bin count store: read-modify-write increment with forwarding, clear sweep.
module hn_store
  import hn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  store_req_t req,
  output store_rsp_t rsp
);

  logic                   clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic                   s1_add_r, s1_rd_r;
  logic [ADDR_W-1:0]      s1_addr_r;
  logic                   fwd_v_r;
  logic [ADDR_W-1:0]      fwd_addr_r;
  logic [COUNT_WIDTH-1:0] fwd_data_r;

  logic                   we;
  logic [ADDR_W-1:0]      waddr;
  logic [COUNT_WIDTH-1:0] wdata;
  logic [COUNT_WIDTH-1:0] rdata;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc;

  hn_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(NUM_BINS)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (req.add | req.rd),
    .raddr(req.addr),
    .rdata(rdata)
  );

  // the word written in the previous cycle is not yet in the read data
  assign cur = (fwd_v_r && fwd_addr_r == s1_addr_r) ? fwd_data_r : rdata;
  assign inc = sat_inc(cur);

  always_comb begin
    if (clr_busy_r) begin
      we    = 1'b1;
      waddr = clr_addr_r;
      wdata = '0;
    end else begin
      we    = s1_add_r;
      waddr = s1_addr_r;
      wdata = inc;
    end
  end

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == ADDR_W'(NUM_BINS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end else if (req.clr) begin
      clr_busy_nxt = 1'b1;
      clr_addr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      s1_add_r   <= 1'b0;
      s1_rd_r    <= 1'b0;
      fwd_v_r    <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      s1_add_r   <= req.add;
      s1_rd_r    <= req.rd;
      fwd_v_r    <= s1_add_r && !clr_busy_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr_r  <= req.addr;
    fwd_addr_r <= s1_addr_r;
    fwd_data_r <= inc;
  end

  assign rsp.clearing = clr_busy_r;
  assign rsp.rd_done  = s1_rd_r;
  assign rsp.rd_count = cur;

endmodule

// ----- design/hn_div.sv -----
// Restoring divider for the Q0.16 bin fraction, one quotient bit per cycle.
module hn_div
  import hn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                 state_r;
  logic [COUNT_WIDTH-1:0] rem_r;
  logic [COUNT_WIDTH-1:0] dvs_r;
  logic [FRAC_W-1:0]      quo_r;
  logic [STEP_W-1:0]      step_r;

  logic [COUNT_WIDTH:0]   shifted;
  logic                   fits;

  assign shifted = {rem_r, 1'b0};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (req.start) begin
            rem_r  <= req.dividend;
            dvs_r  <= req.divisor;
            step_r <= '0;
            if (req.divisor == '0) begin
              quo_r   <= '0;
              state_r <= S_DONE;
            end else if (req.dividend >= req.divisor) begin
              // bin holds the whole total
              quo_r   <= FRAC_MAX;
              state_r <= S_DONE;
            end else begin
              quo_r   <= '0;
              state_r <= S_RUN;
            end
          end
        end
        S_RUN: begin
          rem_r  <= fits ? COUNT_WIDTH'(shifted - {1'b0, dvs_r}) : shifted[COUNT_WIDTH-1:0];
          quo_r  <= {quo_r[FRAC_W-2:0], fits};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(FRAC_W - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (req.ack) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.busy     = (state_r != S_IDLE);
  assign rsp.done     = (state_r == S_DONE);
  assign rsp.quotient = quo_r;

endmodule
